### design/bsc_pkg.sv
package bsc_pkg;

    localparam int unsigned MeasW = 18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WMUL,
        ST_WDIV,
        ST_DONE
    } t_state;

    // microcode steps: T* temperature, P* pressure
    typedef enum logic [3:0] {
        SP_T0, SP_T1, SP_T2,
        SP_P0, SP_P1, SP_P2, SP_P3, SP_P4,
        SP_P5, SP_P6, SP_P7, SP_P8, SP_P9
    } t_step;

    localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
    localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
    localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
    localparam logic [2:0] REG_CAL_PRESS_C = 3'd3;
    localparam logic [2:0] REG_TEMP_OFFSET = 3'd4;

    localparam logic [12:0] TempOffsetReset = 13'h1C18; // -1000

    function automatic logic [63:0] sext16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] sh);
        return $unsigned($signed(v) >>> sh);
    endfunction

    function automatic logic [MeasW-1:0] sat18(input logic [63:0] v);
        logic [MeasW-1:0] r;
        if (v[63]) begin
            if ($signed(v) < -64'sd131072) r = 18'h20000;
            else                           r = v[MeasW-1:0];
        end else begin
            if (v > 64'd131071) r = 18'h1FFFF;
            else                r = v[MeasW-1:0];
        end
        return r;
    endfunction

endpackage

### design/baro_sensor_compensation_core.sv
// Channel   Dir  Beat contents
// s         in   tuser: action; tdata: raw_sample[19:0], zero pad to 24
// m         out  tuser: divide_fault; tdata: measurement[17:0], zero pad to 24
// cfg       in   write enable, index 0..4, 64-bit data
//
// One shared 64-bit shift-add multiplier does all products, each one started
// from the issue state; a bit-serial divider serves the pressure quotient.
// A pressure beat with a zero divisor skips the divide and ends after P5.
// Input is not ready while an item is in work; a finished result waits in
// the output register and the next item may be taken meanwhile.
// Synchronous active-low reset; calibration clears, offset goes to -1000.
module baro_sensor_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // raw_sample[19:0]
    input  logic [0:0]  i_s_tuser,   // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // measurement[17:0]
    output logic [0:0]  o_m_tuser,   // divide_fault
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    bsc_pkg::t_state r_state, n_state;
    bsc_pkg::t_step  r_step, n_step;

    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_pa, r_cal_pb;
    logic [15:0] r_cal_pc;
    logic [12:0] r_toff;
    logic [31:0] r_fine, n_fine;

    logic        r_act;
    logic [19:0] r_adc;
    logic [63:0] r_a, n_a, r_b, n_b, r_q, n_q, r_p, n_p, r_h, n_h;
    logic [17:0] r_res, n_res;
    logic        r_fault, n_fault;

    logic        r_ovalid, n_ovalid;
    logic [17:0] r_omeas, n_omeas;
    logic        r_ofault, n_ofault;

    logic        w_accept;
    logic        w_mul_start, w_mul_done, w_div_start, w_div_done;
    logic [63:0] w_mul_a, w_mul_b, w_prod, w_quo;
    logic [63:0] w_t1, w_t2, w_t3, w_v1;
    logic [63:0] w_tf, w_tf32, w_t, w_pf;

    assign w_accept = i_s_tvalid && o_s_tready;

    assign w_t1 = {48'd0, r_cal_temp[15:0]};
    assign w_t2 = bsc_pkg::sext16(r_cal_temp[31:16]);
    assign w_t3 = bsc_pkg::sext16(r_cal_temp[47:32]);
    assign w_v1 = {{32{r_fine[31]}}, r_fine} - 64'd128000;

    assign w_tf   = r_a + bsc_pkg::asr64(w_prod, 6'd14);
    assign w_tf32 = {{32{w_tf[31]}}, w_tf[31:0]};
    assign w_t    = bsc_pkg::asr64({w_tf32[61:0], 2'b00} + w_tf32 + 64'd128, 6'd8)
                    + {{51{r_toff[12]}}, r_toff};
    assign w_pf   = bsc_pkg::asr64(r_p + r_a + bsc_pkg::asr64(w_prod, 6'd19), 6'd8)
                    + (bsc_pkg::sext16(r_cal_pb[47:32]) << 4);

    // operand select per microcode step
    always_comb begin
        w_mul_a = r_q;
        w_mul_b = r_h;
        case (r_step)
            bsc_pkg::SP_T0: begin
                w_mul_a = {47'd0, r_adc[19:3]} - {w_t1[62:0], 1'b0};
                w_mul_b = w_t2;
            end
            bsc_pkg::SP_T1: begin
                w_mul_a = {48'd0, r_adc[19:4]} - w_t1;
                w_mul_b = {48'd0, r_adc[19:4]} - w_t1;
            end
            bsc_pkg::SP_T2: begin
                w_mul_a = r_q;
                w_mul_b = w_t3;
            end
            bsc_pkg::SP_P0: begin
                w_mul_a = w_v1;
                w_mul_b = w_v1;
            end
            bsc_pkg::SP_P1: begin
                w_mul_a = r_q;
                w_mul_b = bsc_pkg::sext16(r_cal_pb[31:16]);
            end
            bsc_pkg::SP_P2: begin
                w_mul_a = w_v1;
                w_mul_b = bsc_pkg::sext16(r_cal_pb[15:0]);
            end
            bsc_pkg::SP_P3: begin
                w_mul_a = r_q;
                w_mul_b = bsc_pkg::sext16(r_cal_pa[47:32]);
            end
            bsc_pkg::SP_P4: begin
                w_mul_a = w_v1;
                w_mul_b = bsc_pkg::sext16(r_cal_pa[31:16]);
            end
            bsc_pkg::SP_P5: begin
                w_mul_a = r_a + (64'd1 << 47);
                w_mul_b = {48'd0, r_cal_pa[15:0]};
            end
            bsc_pkg::SP_P6: begin
                w_mul_a = ((64'd1048576 - {44'd0, r_adc}) << 31) - r_b;
                w_mul_b = 64'd3125;
            end
            bsc_pkg::SP_P7: begin
                w_mul_a = bsc_pkg::sext16(r_cal_pc);
                w_mul_b = r_h;
            end
            bsc_pkg::SP_P8: begin
                w_mul_a = r_q;
                w_mul_b = r_h;
            end
            bsc_pkg::SP_P9: begin
                w_mul_a = bsc_pkg::sext16(r_cal_pb[63:48]);
                w_mul_b = r_p;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsc_pkg::ST_IDLE:  if (w_accept) n_state = bsc_pkg::ST_ISSUE;
            bsc_pkg::ST_ISSUE: n_state = bsc_pkg::ST_WMUL;
            bsc_pkg::ST_WMUL: begin
                if (w_mul_done) begin
                    case (r_step)
                        bsc_pkg::SP_T2, bsc_pkg::SP_P9: n_state = bsc_pkg::ST_DONE;
                        bsc_pkg::SP_P5: n_state = (bsc_pkg::asr64(w_prod, 6'd33) == 64'd0) ?
                                                  bsc_pkg::ST_DONE : bsc_pkg::ST_ISSUE;
                        bsc_pkg::SP_P6: n_state = bsc_pkg::ST_WDIV;
                        default:        n_state = bsc_pkg::ST_ISSUE;
                    endcase
                end
            end
            bsc_pkg::ST_WDIV:  if (w_div_done) n_state = bsc_pkg::ST_ISSUE;
            bsc_pkg::ST_DONE:  if (!r_ovalid || i_m_tready) n_state = bsc_pkg::ST_IDLE;
            default:           n_state = bsc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_step      = r_step;
        n_fine      = r_fine;
        n_a         = r_a;
        n_b         = r_b;
        n_q         = r_q;
        n_p         = r_p;
        n_h         = r_h;
        n_res       = r_res;
        n_fault     = r_fault;
        n_ovalid    = r_ovalid && !i_m_tready;
        n_omeas     = r_omeas;
        n_ofault    = r_ofault;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            bsc_pkg::ST_IDLE: begin
                n_step  = i_s_tuser[0] ? bsc_pkg::SP_P0 : bsc_pkg::SP_T0;
                n_fault = 1'b0;
            end
            bsc_pkg::ST_ISSUE: w_mul_start = 1'b1;
            bsc_pkg::ST_WMUL: begin
                if (w_mul_done) begin
                    case (r_step)
                        bsc_pkg::SP_T0: begin
                            n_a = bsc_pkg::asr64(w_prod, 6'd11);
                            n_step = bsc_pkg::SP_T1;
                        end
                        bsc_pkg::SP_T1: begin
                            n_q = bsc_pkg::asr64(w_prod, 6'd12);
                            n_step = bsc_pkg::SP_T2;
                        end
                        bsc_pkg::SP_T2: begin
                            n_fine = w_tf[31:0];
                            n_res  = bsc_pkg::sat18(w_t);
                        end
                        bsc_pkg::SP_P0: begin
                            n_q = w_prod;
                            n_step = bsc_pkg::SP_P1;
                        end
                        bsc_pkg::SP_P1: begin
                            n_b = w_prod;
                            n_step = bsc_pkg::SP_P2;
                        end
                        bsc_pkg::SP_P2: begin
                            n_b = r_b + (w_prod << 17)
                                  + (bsc_pkg::sext16(r_cal_pa[63:48]) << 35);
                            n_step = bsc_pkg::SP_P3;
                        end
                        bsc_pkg::SP_P3: begin
                            n_a = bsc_pkg::asr64(w_prod, 6'd8);
                            n_step = bsc_pkg::SP_P4;
                        end
                        bsc_pkg::SP_P4: begin
                            n_a = r_a + (w_prod << 12);
                            n_step = bsc_pkg::SP_P5;
                        end
                        bsc_pkg::SP_P5: begin
                            n_a = bsc_pkg::asr64(w_prod, 6'd33);
                            if (n_a == 64'd0) begin
                                n_res   = '0;
                                n_fault = 1'b1;
                            end
                            n_step = bsc_pkg::SP_P6;
                        end
                        bsc_pkg::SP_P6: w_div_start = 1'b1;
                        bsc_pkg::SP_P7: begin
                            n_q = w_prod;
                            n_step = bsc_pkg::SP_P8;
                        end
                        bsc_pkg::SP_P8: begin
                            n_a = bsc_pkg::asr64(w_prod, 6'd25);
                            n_step = bsc_pkg::SP_P9;
                        end
                        bsc_pkg::SP_P9: n_res = bsc_pkg::sat18(bsc_pkg::asr64(w_pf, 6'd8));
                        default: ;
                    endcase
                end
            end
            bsc_pkg::ST_WDIV: begin
                if (w_div_done) begin
                    n_p    = w_quo;
                    n_h    = bsc_pkg::asr64(w_quo, 6'd13);
                    n_step = bsc_pkg::SP_P7;
                end
            end
            bsc_pkg::ST_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_omeas  = r_res;
                    n_ofault = r_fault;
                end
            end
            default: ;
        endcase
    end

    bsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // divisor is the P5 result held in r_a
    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_a),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsc_pkg::ST_IDLE;
            r_step     <= bsc_pkg::SP_T0;
            r_ovalid   <= 1'b0;
            r_fine     <= '0;
            r_cal_temp <= '0;
            r_cal_pa   <= '0;
            r_cal_pb   <= '0;
            r_cal_pc   <= '0;
            r_toff     <= bsc_pkg::TempOffsetReset;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
            r_fine   <= n_fine;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsc_pkg::REG_CAL_TEMP:    r_cal_temp <= i_cfg_data[47:0];
                    bsc_pkg::REG_CAL_PRESS_A: r_cal_pa   <= i_cfg_data;
                    bsc_pkg::REG_CAL_PRESS_B: r_cal_pb   <= i_cfg_data;
                    bsc_pkg::REG_CAL_PRESS_C: r_cal_pc   <= i_cfg_data[15:0];
                    bsc_pkg::REG_TEMP_OFFSET: r_toff     <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
        if (w_accept) begin
            r_act <= i_s_tuser[0];
            r_adc <= i_s_tdata[19:0];
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_q      <= n_q;
        r_p      <= n_p;
        r_h      <= n_h;
        r_res    <= n_res;
        r_fault  <= n_fault;
        r_omeas  <= n_omeas;
        r_ofault <= n_ofault;
    end

    assign o_s_tready = (r_state == bsc_pkg::ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_omeas};
    assign o_m_tuser  = r_ofault;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[17:0] == 18'd0)
        else $error("fault result with nonzero measurement");

    a_accept_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == bsc_pkg::ST_ISSUE)
        else $error("accepted beat did not start the sequencer");

    a_temp_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> r_act)
        else $error("divider started on a temperature beat");

    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("multiplier and divider finished together");

endmodule

### design/bsc_mul.sv
module bsc_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    // shift-add, one multiplier bit per cycle, product wraps to 64 bits
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mc, n_mc;
    logic [63:0] r_mp, n_mp;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_acc  = '0;
            n_mc   = i_a;
            n_mp   = i_b;
        end else if (r_busy) begin
            if (r_mp[0]) n_acc = r_acc + r_mc;
            n_mc  = {r_mc[62:0], 1'b0};
            n_mp  = {1'b0, r_mp[63:1]};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### design/bsc_div.sv
module bsc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    // signed restoring divide, truncates toward zero, one bit per cycle
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_dvs, n_dvs;
    logic [64:0] w_tmp;

    assign w_tmp = {r_rem, r_quo[63]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_neg  = i_num[63] ^ i_den[63];
            n_rem  = '0;
            n_quo  = i_num[63] ? (64'd0 - i_num) : i_num;
            n_dvs  = i_den[63] ? (64'd0 - i_den) : i_den;
        end else if (r_busy) begin
            if (w_tmp >= {1'b0, r_dvs}) begin
                n_rem = 64'(w_tmp - {1'b0, r_dvs});
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_tmp[63:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (64'd0 - r_quo) : r_quo;

endmodule
